/* src/linear_key_value_table_defines.svh */
// ----------------------------------------------------------------------------
// linear_key_value_table_defines
// assertion macros used by the checker of the key/value table
// ----------------------------------------------------------------------------
`ifndef LINEAR_KEY_VALUE_TABLE_DEFINES_SVH
`define LINEAR_KEY_VALUE_TABLE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define LKVT_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lkvt: property violated");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define LKVT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lkvt: property violated");

`endif

/* src/lkvt_pkg.sv */
// ----------------------------------------------------------------------------
// lkvt_pkg
// types and constants of the linear-search key/value table
// ----------------------------------------------------------------------------
package lkvt_pkg;

  localparam int OPCODE_W = 3;
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 8;
  localparam int COUNT_W  = 9;

  localparam int DEF_CAPACITY   = 256;
  localparam int DEF_KEY_BITS   = 32;
  localparam int DEF_VALUE_BITS = 32;

  // depth of the request queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT    = 3'd0,
    OP_UPDATE    = 3'd1,
    OP_UPSERT    = 3'd2,
    OP_ERASE     = 3'd3,
    OP_CONTAINS  = 3'd4,
    OP_GET_KEY   = 3'd5,
    OP_GET_INDEX = 3'd6,
    OP_INVALID   = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_READ
  } state_e;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [KEY_W-1:0]    key_in;
    logic [VALUE_W-1:0]  value_in;
    logic [INDEX_W-1:0]  index_in;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [KEY_W-1:0]   key_out;
    logic [VALUE_W-1:0] value_out;
    logic [COUNT_W-1:0] count_out;
  } res_t;

  // classified request as it sits in the queue
  typedef struct packed {
    op_e                op;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
  } cmd_t;

endpackage

/* src/linear_key_value_table.sv */
// ----------------------------------------------------------------------------
// linear_key_value_table
// fixed-capacity key/value table kept as a packed list, searched linearly
// ----------------------------------------------------------------------------
// Request channel: a word on req_i is taken at a clock edge where start is
// high and busy is low. Up to two words wait in the request queue; busy is
// high while that queue is full.
// Result channel: done_o is high for exactly one cycle per request with the
// result word on res_o; the receiver cannot hold results off, so results
// leave in request order with nothing to back them up.
// Course of each request in the back end:
//   get_by_index in range reads its entry; index out of range or unknown opcode ends in ST_START
//   key searches scan from position zero and stop on a hit or at the last entry
//   erase on a hit then shifts every later entry down one place
// The search and the shift both walk the single read port of the entry
// memories, one entry each cycle. The result word is registered and
// appears in the cycle after the back end finishes.
// Reset empties the table (count zero) and the queue; entry memories are
// not cleared, only positions below the count are ever read.
// ----------------------------------------------------------------------------
module linear_key_value_table
  import lkvt_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int KEY_BITS   = DEF_KEY_BITS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic done_o,
  output res_t res_o
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  lkvt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (req_i),
    .busy_o      (busy),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  lkvt_back #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .done_o      (done_o),
    .res_o       (res_o)
  );

endmodule

/* src/lkvt_front.sv */
// ----------------------------------------------------------------------------
// lkvt_front
// takes request words, decodes the opcode and queues them for the back end
// ----------------------------------------------------------------------------
module lkvt_front
  import lkvt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic cmd_valid_o,
  output cmd_t cmd_o,
  input  logic cmd_pop_i
);

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            queue_q [QUEUE_DEPTH];
  logic [QW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]   fill_q, fill_d;
  logic            push;
  logic            pop;
  cmd_t            cmd_new;

  assign busy_o      = (fill_q == NW'(QUEUE_DEPTH));
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign push        = start_i && !busy_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    cmd_new.key   = req_i.key_in;
    cmd_new.value = req_i.value_in;
    cmd_new.index = req_i.index_in;
    case (req_i.opcode)
      OP_INSERT:    cmd_new.op = OP_INSERT;
      OP_UPDATE:    cmd_new.op = OP_UPDATE;
      OP_UPSERT:    cmd_new.op = OP_UPSERT;
      OP_ERASE:     cmd_new.op = OP_ERASE;
      OP_CONTAINS:  cmd_new.op = OP_CONTAINS;
      OP_GET_KEY:   cmd_new.op = OP_GET_KEY;
      OP_GET_INDEX: cmd_new.op = OP_GET_INDEX;
      default:      cmd_new.op = OP_INVALID;
    endcase
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QW'(1);
    end
    if (push && !pop) begin
      fill_d = fill_q + NW'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

/* src/lkvt_back.sv */
// ----------------------------------------------------------------------------
// lkvt_back
// executes queued requests against the packed entry memories, one entry a cycle
// ----------------------------------------------------------------------------
module lkvt_back
  import lkvt_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int KEY_BITS   = DEF_KEY_BITS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  output logic done_o,
  output res_t res_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  // entries are no wider than the ports; bits above KEY_BITS/VALUE_BITS read as zero
  localparam int KS = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int VS = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

  logic [KS-1:0] key_mem [CAPACITY];
  logic [VS-1:0] val_mem [CAPACITY];

  state_e        state_q, state_d;
  cmd_t          cmd_q, cmd_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] scan_addr_q, scan_addr_d;
  logic          found_q, found_d;
  logic          done_q, done_d;
  res_t          res_q, res_d;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_key_en;
  logic          wr_val_en;
  logic [AW-1:0] wr_addr;
  logic [KS-1:0] wr_key;
  logic [VS-1:0] wr_val;
  logic [KS-1:0] key_rdata_q;
  logic [VS-1:0] val_rdata_q;

  logic [KS-1:0] cmd_key;
  logic [VS-1:0] cmd_val;
  logic          key_hit;
  logic          last_entry;
  logic          idx_ok;
  logic          full;

  assign cmd_key    = KS'(cmd_q.key);
  assign cmd_val    = VS'(cmd_q.value);
  assign key_hit    = (key_rdata_q == cmd_key);
  assign last_entry = ((CW'(scan_addr_q) + CW'(1)) == count_q);
  assign idx_ok     = (32'(cmd_q.index) < 32'(count_q));
  assign full       = (count_q == CW'(CAPACITY));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        if (cmd_q.op == OP_GET_INDEX) begin
          state_d = idx_ok ? ST_READ : ST_IDLE;
        end else if (cmd_q.op == OP_INVALID) begin
          state_d = ST_IDLE;
        end else begin
          state_d = (count_q == '0) ? ST_DECIDE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (key_hit || last_entry) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (cmd_q.op == OP_ERASE && found_q && !last_entry) begin
          state_d = ST_SHIFT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SHIFT: begin
        if (last_entry) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_pop_o   = 1'b0;
    cmd_d       = cmd_q;
    count_d     = count_q;
    scan_addr_d = scan_addr_q;
    found_d     = found_q;
    rd_en       = 1'b0;
    rd_addr     = scan_addr_q + AW'(1);
    wr_key_en   = 1'b0;
    wr_val_en   = 1'b0;
    wr_addr     = scan_addr_q;
    wr_key      = cmd_key;
    wr_val      = cmd_val;
    done_d      = 1'b0;
    res_d       = '0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
        end
      end
      ST_START: begin
        if (cmd_q.op == OP_GET_INDEX) begin
          if (idx_ok) begin
            rd_en   = 1'b1;
            rd_addr = AW'(cmd_q.index);
          end else begin
            done_d = 1'b1;
          end
        end else if (cmd_q.op == OP_INVALID) begin
          done_d = 1'b1;
        end else begin
          found_d     = 1'b0;
          scan_addr_d = '0;
          if (count_q != '0) begin
            rd_en   = 1'b1;
            rd_addr = '0;
          end
        end
      end
      ST_SCAN: begin
        if (key_hit) begin
          found_d = 1'b1;
        end else if (!last_entry) begin
          rd_en       = 1'b1;
          scan_addr_d = scan_addr_q + AW'(1);
        end
      end
      ST_DECIDE: begin
        case (cmd_q.op)
          OP_INSERT, OP_UPDATE, OP_UPSERT: begin
            done_d = 1'b1;
            if (found_q) begin
              if (cmd_q.op != OP_INSERT) begin
                wr_val_en = 1'b1;
                res_d.ok  = 1'b1;
              end
            end else if (cmd_q.op != OP_UPDATE && !full) begin
              wr_key_en = 1'b1;
              wr_val_en = 1'b1;
              wr_addr   = AW'(count_q);
              count_d   = count_q + CW'(1);
              res_d.ok  = 1'b1;
            end
          end
          OP_ERASE: begin
            if (!found_q) begin
              done_d = 1'b1;
            end else if (last_entry) begin
              count_d  = count_q - CW'(1);
              done_d   = 1'b1;
              res_d.ok = 1'b1;
            end else begin
              rd_en       = 1'b1;
              scan_addr_d = scan_addr_q + AW'(1);
            end
          end
          OP_CONTAINS: begin
            done_d   = 1'b1;
            res_d.ok = found_q;
          end
          OP_GET_KEY: begin
            done_d   = 1'b1;
            res_d.ok = found_q;
            if (found_q) begin
              res_d.value_out = VALUE_W'(val_rdata_q);
            end
          end
          default: begin
            done_d = 1'b1;
          end
        endcase
      end
      ST_SHIFT: begin
        // entry at scan_addr_q moves down one place
        wr_key_en = 1'b1;
        wr_val_en = 1'b1;
        wr_addr   = scan_addr_q - AW'(1);
        wr_key    = key_rdata_q;
        wr_val    = val_rdata_q;
        if (last_entry) begin
          count_d  = count_q - CW'(1);
          done_d   = 1'b1;
          res_d.ok = 1'b1;
        end else begin
          rd_en       = 1'b1;
          scan_addr_d = scan_addr_q + AW'(1);
        end
      end
      ST_READ: begin
        done_d          = 1'b1;
        res_d.ok        = 1'b1;
        res_d.key_out   = KEY_W'(key_rdata_q);
        res_d.value_out = VALUE_W'(val_rdata_q);
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
    res_d.count_out = COUNT_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    scan_addr_q <= scan_addr_d;
    found_q     <= found_d;
    res_q       <= res_d;
  end

  // entry memories: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_key_en) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (wr_val_en) begin
      val_mem[wr_addr] <= wr_val;
    end
    if (rd_en) begin
      key_rdata_q <= key_mem[rd_addr];
      val_rdata_q <= val_mem[rd_addr];
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* src/lkvt_checker.sv */
// ----------------------------------------------------------------------------
// lkvt_checker
// port-level properties of the key/value table, bound to the top level
// ----------------------------------------------------------------------------
`include "linear_key_value_table_defines.svh"

module lkvt_checker
  import lkvt_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input res_t res_o
);

  // a failed request never returns stored data
  `LKVT_ASSERT_IMPLY(a_miss_zero, done_o && !res_o.ok, res_o.key_out == '0 && res_o.value_out == '0)

  // a nonzero key only comes back from a successful read
  `LKVT_ASSERT_IMPLY(a_key_needs_ok, done_o && res_o.key_out != '0, res_o.ok)

  // the queue only fills up on a taken word
  `LKVT_ASSERT_NEXT(a_busy_after_start, !start, !$rose(busy))

endmodule

bind linear_key_value_table lkvt_checker u_lkvt_checker (.*);

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the linear-search key/value table: a directed table
// of request words, a fill to capacity and drain, then random words from small
// key pools; every result word is checked against the row's own result word
// or a bench-side table model
module tb;
  import lkvt_pkg::*;

  localparam int CAP          = DEF_CAPACITY;
  localparam int PHASE_WORDS  = 375;
  localparam int DRAIN_CYCLES = CAP + 40;
  localparam int N_ROWS       = 24;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t req_i  = '0;
  logic busy;
  logic done_o;
  res_t res_o;

  linear_key_value_table dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .req_i (req_i),
    .busy  (busy),
    .done_o(done_o),
    .res_o (res_o)
  );

  always #5 clk_i = ~clk_i;

  // bench copy of the stored entries, kept packed like the block's list
  logic [KEY_W-1:0]   model_key   [CAP];
  logic [VALUE_W-1:0] model_value [CAP];
  int                 model_count = 0;

  res_t               pending_results [$];
  logic [KEY_W-1:0]   key_pool [$];
  int unsigned        error_count  = 0;
  int unsigned        words_sent   = 0;
  int unsigned        results_seen = 0;
  int unsigned        hit_count    = 0;
  int unsigned        peak_count   = 0;
  int unsigned        op_hist [8];
  int unsigned        idle_pct     = 0;

  typedef struct packed {
    op_e                op;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
    logic               typed;
    res_t               want;
  } stim_row_t;

  // typed rows carry their result word; the others go through the model
  stim_row_t stim_rows [N_ROWS] = '{
    '{OP_GET_INDEX, 32'h0,        32'h0,        8'd0,   1'b1, '{1'b0, 32'h0, 32'h0, 9'd0}},
    '{OP_CONTAINS,  32'h0,        32'h0,        8'd0,   1'b1, '{1'b0, 32'h0, 32'h0, 9'd0}},
    '{OP_ERASE,     32'hFFFFFFFF, 32'h0,        8'd0,   1'b1, '{1'b0, 32'h0, 32'h0, 9'd0}},
    '{OP_UPDATE,    32'h5,        32'hFFFFFFFF, 8'd0,   1'b1, '{1'b0, 32'h0, 32'h0, 9'd0}},
    '{OP_INSERT,    32'h0,        32'hFFFFFFFF, 8'd0,   1'b1, '{1'b1, 32'h0, 32'h0, 9'd1}},
    '{OP_INSERT,    32'hFFFFFFFF, 32'h0,        8'd0,   1'b1, '{1'b1, 32'h0, 32'h0, 9'd2}},
    '{OP_INSERT,    32'h0,        32'h1,        8'd0,   1'b1, '{1'b0, 32'h0, 32'h0, 9'd2}},
    '{OP_GET_KEY,   32'hFFFFFFFF, 32'h0,        8'd0,   1'b1, '{1'b1, 32'h0, 32'h0, 9'd2}},
    '{OP_GET_KEY,   32'h0,        32'h0,        8'd0,   1'b1,
      '{1'b1, 32'h0, 32'hFFFFFFFF, 9'd2}},
    '{OP_GET_INDEX, 32'h0,        32'h0,        8'd1,   1'b1,
      '{1'b1, 32'hFFFFFFFF, 32'h0, 9'd2}},
    '{OP_GET_INDEX, 32'h0,        32'h0,        8'hFF,  1'b1, '{1'b0, 32'h0, 32'h0, 9'd2}},
    '{OP_GET_INDEX, 32'h0,        32'h0,        8'd2,   1'b1, '{1'b0, 32'h0, 32'h0, 9'd2}},
    '{OP_UPSERT,    32'h0,        32'h12345678, 8'd0,   1'b0, '0},
    '{OP_UPSERT,    32'hA5A5A5A5, 32'h5A5A5A5A, 8'd0,   1'b0, '0},
    '{OP_UPDATE,    32'hFFFFFFFF, 32'hDEADBEEF, 8'd0,   1'b0, '0},
    '{OP_INVALID,   32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF,  1'b1, '{1'b0, 32'h0, 32'h0, 9'd3}},
    '{OP_ERASE,     32'h0,        32'h0,        8'd0,   1'b0, '0},
    '{OP_GET_INDEX, 32'h0,        32'h0,        8'd0,   1'b0, '0},
    '{OP_GET_INDEX, 32'h0,        32'h0,        8'd1,   1'b0, '0},
    '{OP_CONTAINS,  32'hFFFFFFFF, 32'h0,        8'd0,   1'b0, '0},
    '{OP_ERASE,     32'hA5A5A5A5, 32'h0,        8'd0,   1'b0, '0},
    '{OP_GET_KEY,   32'h0,        32'h0,        8'd0,   1'b0, '0},
    '{OP_ERASE,     32'hFFFFFFFF, 32'h0,        8'd0,   1'b0, '0},
    '{OP_GET_INDEX, 32'h0,        32'h0,        8'd0,   1'b1, '{1'b0, 32'h0, 32'h0, 9'd0}}
  };

  function automatic int find_entry(input logic [KEY_W-1:0] k);
    for (int p = 0; p < model_count; p++) begin
      if (model_key[p] == k) return p;
    end
    return -1;
  endfunction

  // applies one request word to the bench table and returns its result word
  function automatic res_t apply_request(input req_t w);
    res_t r;
    int   hit;
    op_e  op;
    r   = '0;
    op  = op_e'(w.opcode);
    hit = find_entry(w.key_in);
    case (op)
      OP_INSERT, OP_UPDATE, OP_UPSERT: begin
        if (hit >= 0) begin
          if (op != OP_INSERT) begin
            model_value[hit] = w.value_in;
            r.ok = 1'b1;
          end
        end else if (op != OP_UPDATE && model_count < CAP) begin
          model_key[model_count]   = w.key_in;
          model_value[model_count] = w.value_in;
          model_count++;
          r.ok = 1'b1;
        end
      end
      OP_ERASE: begin
        if (hit >= 0) begin
          for (int p = hit; p + 1 < model_count; p++) begin
            model_key[p]   = model_key[p+1];
            model_value[p] = model_value[p+1];
          end
          model_count--;
          r.ok = 1'b1;
        end
      end
      OP_CONTAINS: r.ok = (hit >= 0);
      OP_GET_KEY: begin
        if (hit >= 0) begin
          r.ok        = 1'b1;
          r.value_out = model_value[hit];
        end
      end
      OP_GET_INDEX: begin
        if (int'(w.index_in) < model_count) begin
          r.ok        = 1'b1;
          r.key_out   = model_key[w.index_in];
          r.value_out = model_value[w.index_in];
        end
      end
      default: ;
    endcase
    r.count_out = COUNT_W'(model_count);
    return r;
  endfunction

  function automatic req_t make_word(input op_e op, input logic [KEY_W-1:0] k,
                                     input logic [VALUE_W-1:0] v,
                                     input logic [INDEX_W-1:0] idx);
    req_t w;
    w.opcode   = op;
    w.key_in   = k;
    w.value_in = v;
    w.index_in = idx;
    return w;
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    do k = $urandom; while (find_entry(k) >= 0);
    return k;
  endfunction

  function automatic req_t random_word();
    int unsigned r;
    op_e         op;
    req_t        w;
    r = $urandom_range(99);
    if (r < 18)      op = OP_INSERT;
    else if (r < 30) op = OP_UPDATE;
    else if (r < 48) op = OP_UPSERT;
    else if (r < 63) op = OP_ERASE;
    else if (r < 73) op = OP_CONTAINS;
    else if (r < 85) op = OP_GET_KEY;
    else if (r < 98) op = OP_GET_INDEX;
    else             op = OP_INVALID;
    w.opcode   = op;
    // keys mostly from the phase pool so that hits, updates and erases happen
    w.key_in   = ($urandom_range(99) < 95) ? key_pool[$urandom_range(key_pool.size() - 1)]
                                           : KEY_W'($urandom);
    w.value_in = $urandom;
    w.index_in = ($urandom_range(3) == 0) ? INDEX_W'($urandom_range(255))
                                          : INDEX_W'($urandom_range(model_count));
    return w;
  endfunction

  // drives one word, waits for it to be taken, then queues its result word
  task automatic issue(input req_t w, input logic typed, input res_t want);
    res_t predicted;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    req_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predicted = apply_request(w);
    pending_results.push_back(typed ? want : predicted);
    words_sent++;
    op_hist[w.opcode]++;
    if (predicted.ok) hit_count++;
    if (model_count > peak_count) peak_count = model_count;
  endtask

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result word with none expected: %h", res_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (res_o.ok !== want.ok) begin
          $error("ok: expected %0b, got %0b", want.ok, res_o.ok);
          error_count++;
        end
        if (res_o.key_out !== want.key_out) begin
          $error("key_out: expected %h, got %h", want.key_out, res_o.key_out);
          error_count++;
        end
        if (res_o.value_out !== want.value_out) begin
          $error("value_out: expected %h, got %h", want.value_out, res_o.value_out);
          error_count++;
        end
        if (res_o.count_out !== want.count_out) begin
          $error("count_out: expected %0d, got %0d", want.count_out, res_o.count_out);
          error_count++;
        end
      end
    end
  end

  initial begin
    #30_000_000;
    $display("timeout: %0d result words still outstanding", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int unsigned      pool_sizes [4];
    int unsigned      phase_idle [4];
    logic [KEY_W-1:0] k;
    pool_sizes = '{4, 16, 64, 32};
    phase_idle = '{0, 65, 0, 33};
    foreach (op_hist[i]) op_hist[i] = 0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) begin
      issue(make_word(stim_rows[i].op, stim_rows[i].key, stim_rows[i].value,
                      stim_rows[i].index), stim_rows[i].typed, stim_rows[i].want);
    end

    // fill to capacity, probe the full table, then erase everything
    idle_pct = 33;
    while (model_count < CAP) issue(make_word(OP_INSERT, fresh_key(), $urandom, '0), 1'b0, '0);
    issue(make_word(OP_INSERT, fresh_key(), $urandom, '0), 1'b0, '0);
    issue(make_word(OP_UPSERT, fresh_key(), $urandom, '0), 1'b0, '0);
    issue(make_word(OP_UPSERT, model_key[$urandom_range(CAP - 1)], $urandom, '0), 1'b0, '0);
    issue(make_word(OP_INSERT, model_key[CAP-1], $urandom, '0), 1'b0, '0);
    issue(make_word(OP_UPDATE, model_key[CAP-1], $urandom, '0), 1'b0, '0);
    issue(make_word(OP_GET_KEY, model_key[CAP-1], '0, '0), 1'b0, '0);
    issue(make_word(OP_GET_INDEX, '0, '0, 8'hFF), 1'b0, '0);
    issue(make_word(OP_ERASE, model_key[CAP/2], '0, '0), 1'b0, '0);
    issue(make_word(OP_GET_INDEX, '0, '0, 8'hFF), 1'b0, '0);
    issue(make_word(OP_UPSERT, fresh_key(), $urandom, '0), 1'b0, '0);
    idle_pct = 0;
    while (model_count > 0) begin
      k = model_key[$urandom_range(model_count - 1)];
      issue(make_word(OP_ERASE, k, $urandom, '0), 1'b0, '0);
    end

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_idle[ph];
      key_pool.delete();
      for (int j = 0; j < pool_sizes[ph]; j++) key_pool.push_back($urandom);
      for (int n = 0; n < PHASE_WORDS; n++) issue(random_word(), 1'b0, '0);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d request words sent, %0d result words checked, %0d hits, peak count %0d",
             words_sent, results_seen, hit_count, peak_count);
    $display("per opcode: ins %0d upd %0d ups %0d era %0d has %0d getk %0d geti %0d bad %0d",
             op_hist[0], op_hist[1], op_hist[2], op_hist[3], op_hist[4], op_hist[5],
             op_hist[6], op_hist[7]);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/lkvt_pkg.sv
src/lkvt_front.sv
src/lkvt_back.sv
src/linear_key_value_table.sv
src/lkvt_checker.sv
sim/tb.sv
